// ----- rtl/core/assert_macros.svh -----
// Assertion macros for the RTL files of the decimal formatter (included by the top level).
// Define NO_ASSERTIONS to drop every check from the build.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, checked at every rising edge out of reset.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, checked at every rising edge out of reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ----- rtl/core/idf_pkg.sv -----
// Shared constants of the integer decimal formatter: defaults, widths,
// register indexes and ASCII codes. No dependencies.
`default_nettype none

package idf_pkg;

    localparam int VALUE_BITS_DEF = 64;
    localparam int MAX_DIGITS_DEF = 20;
    localparam int FIELD_MAX_DEF  = 63;

    localparam int DIGIT_W   = 4;
    localparam int CNT_W     = 7;
    localparam int CFG_W     = 7;
    localparam int CFG_IDX_W = 3;
    localparam int CHAR_W    = 7;

    localparam logic [CFG_IDX_W-1:0] REG_FIELD_WIDTH = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_DIGITS  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SHOW_PLUS   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPACE_SIGN  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ZERO_FILL   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ALIGN_LEFT  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SIGNED_MODE = 3'd6;

    localparam logic [CHAR_W-1:0] CH_ZERO  = 7'h30;
    localparam logic [CHAR_W-1:0] CH_SPACE = 7'h20;
    localparam logic [CHAR_W-1:0] CH_MINUS = 7'h2d;
    localparam logic [CHAR_W-1:0] CH_PLUS  = 7'h2b;

endpackage

`default_nettype wire

// ----- rtl/core/idf_dabble.sv -----
// Bit-serial binary to BCD converter (shift and add-3), one input bit a cycle.
// Depends on idf_pkg for the digit width.
`default_nettype none

module idf_dabble #(
    parameter int VALUE_BITS = idf_pkg::VALUE_BITS_DEF,
    parameter int MAX_DIGITS = idf_pkg::MAX_DIGITS_DEF
) (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   load,
    input  wire logic [VALUE_BITS-1:0]                  mag,
    output logic                                        done,
    output logic [idf_pkg::DIGIT_W*MAX_DIGITS-1:0]      bcd
);

    localparam int BCD_W = idf_pkg::DIGIT_W * MAX_DIGITS;
    localparam int BC_W  = $clog2(VALUE_BITS + 1);

    logic                  run_reg, run_next;
    logic                  done_reg, done_next;
    logic [BC_W-1:0]       cnt_reg, cnt_next;
    logic [VALUE_BITS-1:0] mag_reg, mag_next;
    logic [BCD_W-1:0]      bcd_reg, bcd_next;
    logic [BCD_W-1:0]      bcd_adj;

    always_comb
    begin
        logic [idf_pkg::DIGIT_W-1:0] d;
        d = '0;
        for (int i = 0; i < MAX_DIGITS; i++)
        begin
            d = bcd_reg[i*idf_pkg::DIGIT_W +: idf_pkg::DIGIT_W];
            bcd_adj[i*idf_pkg::DIGIT_W +: idf_pkg::DIGIT_W] =
                (d >= 4'd5) ? d + 4'd3 : d;
        end
    end

    always_comb
    begin
        run_next  = run_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        mag_next  = mag_reg;
        bcd_next  = bcd_reg;
        if (load)
        begin
            run_next = 1'b1;
            cnt_next = BC_W'(VALUE_BITS);
            mag_next = mag;
            bcd_next = '0;
        end
        else if (run_reg)
        begin
            bcd_next = {bcd_adj[BCD_W-2:0], mag_reg[VALUE_BITS-1]};
            mag_next = {mag_reg[VALUE_BITS-2:0], 1'b0};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == BC_W'(1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg <= mag_next;
        bcd_reg <= bcd_next;
    end

    assign done = done_reg;
    assign bcd  = bcd_reg;

endmodule

`default_nettype wire

// ----- rtl/core/integer_decimal_formatter_top.sv -----
// Sequence: load, bit-serial BCD conversion, capture, leading-zero scan over up to MAX_DIGITS
// digits, sizing in ST_SIZE and ST_PLAN, then one character a cycle, with extra steps for
// empty text segments. The bit-serial BCD converter and the one-character-a-cycle output
// register set how long a value takes; a new start is accepted only while busy is low.
// busy is high from the accepted start until the last character is issued.
// Reset (rst_n low, asynchronous) returns to idle and loads register defaults; no stall.
`default_nettype none
`include "assert_macros.svh"

module integer_decimal_formatter_top #(
    parameter int VALUE_BITS = idf_pkg::VALUE_BITS_DEF,
    parameter int MAX_DIGITS = idf_pkg::MAX_DIGITS_DEF,
    parameter int FIELD_MAX  = idf_pkg::FIELD_MAX_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            start,
    output logic                                 busy,
    input  wire logic [63:0]                     value,
    input  wire logic                            wr_en,
    input  wire logic [idf_pkg::CFG_IDX_W-1:0]   wr_index,
    input  wire logic [idf_pkg::CFG_W-1:0]       wr_data,
    output logic                                 strobe,
    output logic [idf_pkg::CHAR_W-1:0]           out_char,
    output logic                                 last
);

    localparam int CNT_W = idf_pkg::CNT_W;
    localparam int DW    = idf_pkg::DIGIT_W;
    localparam int BCD_W = DW * MAX_DIGITS;
    localparam logic [CNT_W-1:0] FIELD_LIM = CNT_W'(FIELD_MAX);

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_CONV = 4'd1;
    localparam logic [3:0] ST_SCAN = 4'd2;
    localparam logic [3:0] ST_SIZE = 4'd3;
    localparam logic [3:0] ST_PLAN = 4'd4;
    localparam logic [3:0] ST_PRE  = 4'd5;
    localparam logic [3:0] ST_SIGN = 4'd6;
    localparam logic [3:0] ST_LEAD = 4'd7;
    localparam logic [3:0] ST_DIG  = 4'd8;
    localparam logic [3:0] ST_POST = 4'd9;

    logic [5:0] field_width_reg;
    logic [6:0] min_digits_reg;
    logic       show_plus_reg;
    logic       space_sign_reg;
    logic       zero_fill_reg;
    logic       align_left_reg;
    logic       signed_mode_reg;

    logic [3:0]                  state_reg, state_next;
    logic                        strobe_reg, strobe_next;
    logic [idf_pkg::CHAR_W-1:0]  char_reg, char_next;
    logic                        last_reg, last_next;
    logic [idf_pkg::CHAR_W-1:0]  sign_char_reg, sign_char_next;
    logic                        has_sign_reg, has_sign_next;
    logic [BCD_W-1:0]            digits_reg, digits_next;
    logic [CNT_W-1:0]            nd_reg, nd_next;
    logic [CNT_W-1:0]            zeros_reg, zeros_next;
    logic [CNT_W-1:0]            core_reg, core_next;
    logic [CNT_W-1:0]            pre_reg, pre_next;
    logic [CNT_W-1:0]            lead_reg, lead_next;
    logic [CNT_W-1:0]            post_reg, post_next;
    logic [CNT_W-1:0]            total_reg, total_next;

    logic                  accept;
    logic [VALUE_BITS-1:0] raw;
    logic                  negative;
    logic [VALUE_BITS-1:0] mag;
    logic                  conv_done;
    logic [BCD_W-1:0]      conv_bcd;
    logic                  has_prec;
    logic [CNT_W-1:0]      prec;
    logic [CNT_W-1:0]      width_c;
    logic                  zf_mode;
    logic [CNT_W-1:0]      pad;
    logic [DW-1:0]         top_digit;

    assign accept   = start && !busy;
    assign raw      = value[VALUE_BITS-1:0];
    assign negative = signed_mode_reg && raw[VALUE_BITS-1];
    assign mag      = negative ? (~raw + 1'b1) : raw;

    assign has_prec  = !min_digits_reg[6];
    assign prec      = has_prec ? {1'b0, min_digits_reg[5:0]} : '0;
    assign width_c   = ({1'b0, field_width_reg} > FIELD_LIM) ? FIELD_LIM
                                                              : {1'b0, field_width_reg};
    assign zf_mode   = !has_prec && zero_fill_reg && !align_left_reg;
    assign pad       = (width_c > core_reg) ? width_c - core_reg : '0;
    assign top_digit = digits_reg[BCD_W-1 -: DW];

    idf_dabble #(
        .VALUE_BITS (VALUE_BITS),
        .MAX_DIGITS (MAX_DIGITS)
    ) u_dabble (
        .clk   (clk),
        .rst_n (rst_n),
        .load  (accept),
        .mag   (mag),
        .done  (conv_done),
        .bcd   (conv_bcd)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            field_width_reg <= '0;
            min_digits_reg  <= 7'h7f;
            show_plus_reg   <= 1'b0;
            space_sign_reg  <= 1'b0;
            zero_fill_reg   <= 1'b0;
            align_left_reg  <= 1'b0;
            signed_mode_reg <= 1'b1;
        end
        else if (wr_en)
        begin
            case (wr_index)
                idf_pkg::REG_FIELD_WIDTH: field_width_reg <= wr_data[5:0];
                idf_pkg::REG_MIN_DIGITS:  min_digits_reg  <= wr_data;
                idf_pkg::REG_SHOW_PLUS:   show_plus_reg   <= wr_data[0];
                idf_pkg::REG_SPACE_SIGN:  space_sign_reg  <= wr_data[0];
                idf_pkg::REG_ZERO_FILL:   zero_fill_reg   <= wr_data[0];
                idf_pkg::REG_ALIGN_LEFT:  align_left_reg  <= wr_data[0];
                idf_pkg::REG_SIGNED_MODE: signed_mode_reg <= wr_data[0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        strobe_next    = 1'b0;
        char_next      = char_reg;
        last_next      = last_reg;
        sign_char_next = sign_char_reg;
        has_sign_next  = has_sign_reg;
        digits_next    = digits_reg;
        nd_next        = nd_reg;
        zeros_next     = zeros_reg;
        core_next      = core_reg;
        pre_next       = pre_reg;
        lead_next      = lead_reg;
        post_next      = post_reg;
        total_next     = total_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    has_sign_next  = signed_mode_reg &&
                                     (negative || show_plus_reg || space_sign_reg);
                    sign_char_next = negative ? idf_pkg::CH_MINUS :
                                     show_plus_reg ? idf_pkg::CH_PLUS : idf_pkg::CH_SPACE;
                    state_next     = ST_CONV;
                end
            end
            ST_CONV:
            begin
                if (conv_done)
                begin
                    digits_next = conv_bcd;
                    nd_next     = CNT_W'(MAX_DIGITS);
                    state_next  = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (nd_reg != '0 && top_digit == '0)
                begin
                    digits_next = digits_reg << DW;
                    nd_next     = nd_reg - 1'b1;
                end
                else
                begin
                    if (nd_reg == '0 && !(has_prec && prec == '0))
                    begin
                        nd_next = CNT_W'(1);
                    end
                    state_next = ST_SIZE;
                end
            end
            ST_SIZE:
            begin
                zeros_next = (prec > nd_reg) ? prec - nd_reg : '0;
                core_next  = ((prec > nd_reg) ? prec : nd_reg) + CNT_W'(has_sign_reg);
                state_next = ST_PLAN;
            end
            ST_PLAN:
            begin
                pre_next   = (!align_left_reg && !zf_mode) ? pad : '0;
                lead_next  = zeros_reg + (zf_mode ? pad : '0);
                post_next  = align_left_reg ? pad : '0;
                total_next = pad + core_reg;
                state_next = ST_PRE;
            end
            ST_PRE, ST_SIGN, ST_LEAD, ST_DIG, ST_POST:
            begin
                if (total_reg == '0)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    case (state_reg)
                        ST_PRE:
                        begin
                            if (pre_reg == '0)
                            begin
                                state_next = ST_SIGN;
                            end
                            else
                            begin
                                strobe_next = 1'b1;
                                char_next   = idf_pkg::CH_SPACE;
                                pre_next    = pre_reg - 1'b1;
                            end
                        end
                        ST_SIGN:
                        begin
                            state_next = ST_LEAD;
                            if (has_sign_reg)
                            begin
                                strobe_next = 1'b1;
                                char_next   = sign_char_reg;
                            end
                        end
                        ST_LEAD:
                        begin
                            if (lead_reg == '0)
                            begin
                                state_next = ST_DIG;
                            end
                            else
                            begin
                                strobe_next = 1'b1;
                                char_next   = idf_pkg::CH_ZERO;
                                lead_next   = lead_reg - 1'b1;
                            end
                        end
                        ST_DIG:
                        begin
                            if (nd_reg == '0)
                            begin
                                state_next = ST_POST;
                            end
                            else
                            begin
                                strobe_next = 1'b1;
                                char_next   = {3'b011, top_digit};
                                digits_next = digits_reg << DW;
                                nd_next     = nd_reg - 1'b1;
                            end
                        end
                        default:
                        begin
                            if (post_reg != '0)
                            begin
                                strobe_next = 1'b1;
                                char_next   = idf_pkg::CH_SPACE;
                                post_next   = post_reg - 1'b1;
                            end
                        end
                    endcase
                    if (strobe_next)
                    begin
                        last_next  = (total_reg == CNT_W'(1));
                        total_next = total_reg - 1'b1;
                        if (total_reg == CNT_W'(1))
                        begin
                            state_next = ST_IDLE;
                        end
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            strobe_reg <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        char_reg      <= char_next;
        last_reg      <= last_next;
        sign_char_reg <= sign_char_next;
        has_sign_reg  <= has_sign_next;
        digits_reg    <= digits_next;
        nd_reg        <= nd_next;
        zeros_reg     <= zeros_next;
        core_reg      <= core_next;
        pre_reg       <= pre_next;
        lead_reg      <= lead_next;
        post_reg      <= post_next;
        total_reg     <= total_next;
    end

    assign busy     = (state_reg != ST_IDLE);
    assign strobe   = strobe_reg;
    assign out_char = char_reg;
    assign last     = last_reg;

    `ASSERT_NEXT(a_start_busy, clk, rst_n, accept, busy)
    `ASSERT_IMPLIES(a_mid_busy, clk, rst_n, strobe_reg && !last_reg, busy)
    `ASSERT_IMPLIES(a_last_idle, clk, rst_n, strobe_reg && last_reg, state_reg == ST_IDLE)
    `ASSERT_IMPLIES(a_done_conv, clk, rst_n, conv_done, state_reg == ST_CONV)

endmodule

`default_nettype wire

// ----- tb/sv/integer_decimal_formatter_top_tb.sv -----
// Self-checking testbench for integer_decimal_formatter_top: predicts the printf-style
// decimal text of each accepted value and checks every character word against it.
// Depends on idf_pkg and the formatter RTL only.
module integer_decimal_formatter_top_tb;

    localparam int                            TEXT_LIMIT = 64;
    localparam int                            TAIL_WAIT  = 150;
    localparam logic [idf_pkg::CFG_IDX_W-1:0] REG_NONE   = 3'd7;

    typedef struct packed {
        logic [idf_pkg::CHAR_W-1:0] ch;
        logic                       last;
    } char_word_t;

    logic                          clk      = 1'b0;
    logic                          rst_n    = 1'b0;
    logic                          start    = 1'b0;
    logic [63:0]                   value    = 64'd0;
    logic                          wr_en    = 1'b0;
    logic [idf_pkg::CFG_IDX_W-1:0] wr_index = '0;
    logic [idf_pkg::CFG_W-1:0]     wr_data  = '0;
    logic                          busy;
    logic                          strobe;
    logic [idf_pkg::CHAR_W-1:0]    out_char;
    logic                          last;

    logic [5:0]        cfg_width     = 6'd0;
    logic signed [6:0] cfg_precision = -7'sd1;
    logic              cfg_plus      = 1'b0;
    logic              cfg_space     = 1'b0;
    logic              cfg_zero_fill = 1'b0;
    logic              cfg_left      = 1'b0;
    logic              cfg_signed    = 1'b1;

    char_word_t pending_chars[$];
    int         mismatch_count = 0;
    int         idle_pct       = 0;

    integer_decimal_formatter_top uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .value    (value),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .strobe   (strobe),
        .out_char (out_char),
        .last     (last)
    );

    always #10 clk = ~clk;

    task automatic report_mismatch(input string msg);
        $display("ERROR at %0t: %s", $time, msg);
        mismatch_count++;
    endtask

    function automatic void format_decimal(input logic [63:0] raw);
        logic [63:0]                mag;
        logic [idf_pkg::CHAR_W-1:0] sign_ch;
        logic [idf_pkg::CHAR_W-1:0] digit_chars [idf_pkg::MAX_DIGITS_DEF];
        logic [idf_pkg::CHAR_W-1:0] text [$];
        bit                         has_sign;
        bit                         has_prec;
        int                         prec;
        int                         width;
        int                         nd;
        int                         zeros;
        int                         body_len;
        int                         pad;
        int                         count;
        int                         i;
        char_word_t                 w;
        mag      = raw;
        has_sign = 1'b0;
        sign_ch  = idf_pkg::CH_SPACE;
        nd       = 0;
        has_prec = !cfg_precision[6];
        prec     = has_prec ? int'(cfg_precision[5:0]) : 0;
        width    = int'(cfg_width);
        if (width > idf_pkg::FIELD_MAX_DEF)
        begin
            width = idf_pkg::FIELD_MAX_DEF;
        end
        if (cfg_signed && raw[63])
        begin
            mag      = 64'd0 - raw;
            has_sign = 1'b1;
            sign_ch  = idf_pkg::CH_MINUS;
        end
        else if (cfg_signed && cfg_plus)
        begin
            has_sign = 1'b1;
            sign_ch  = idf_pkg::CH_PLUS;
        end
        else if (cfg_signed && cfg_space)
        begin
            has_sign = 1'b1;
            sign_ch  = idf_pkg::CH_SPACE;
        end
        while (mag != 64'd0 && nd < idf_pkg::MAX_DIGITS_DEF)
        begin
            digit_chars[nd] = idf_pkg::CH_ZERO + idf_pkg::CHAR_W'(mag % 64'd10);
            mag = mag / 64'd10;
            nd++;
        end
        if (nd == 0 && !(has_prec && prec == 0))
        begin
            digit_chars[0] = idf_pkg::CH_ZERO;
            nd = 1;
        end
        zeros    = prec > nd ? prec - nd : 0;
        body_len = int'(has_sign) + zeros + nd;
        pad      = width > body_len ? width - body_len : 0;
        if (!has_prec && cfg_zero_fill && !cfg_left)
        begin
            if (has_sign)
            begin
                text.push_back(sign_ch);
            end
            repeat (pad) text.push_back(idf_pkg::CH_ZERO);
        end
        else
        begin
            if (!cfg_left)
            begin
                repeat (pad) text.push_back(idf_pkg::CH_SPACE);
            end
            if (has_sign)
            begin
                text.push_back(sign_ch);
            end
        end
        repeat (zeros) text.push_back(idf_pkg::CH_ZERO);
        for (i = nd - 1; i >= 0; i--)
        begin
            text.push_back(digit_chars[i]);
        end
        if (cfg_left)
        begin
            repeat (pad) text.push_back(idf_pkg::CH_SPACE);
        end
        count = text.size() > TEXT_LIMIT ? TEXT_LIMIT : text.size();
        for (i = 0; i < count; i++)
        begin
            w.ch   = text[i];
            w.last = (i == count - 1);
            pending_chars.push_back(w);
        end
    endfunction

    always @(posedge clk)
    begin
        char_word_t want;
        if (rst_n && strobe)
        begin
            if (pending_chars.size() == 0)
            begin
                report_mismatch($sformatf("unexpected character %h last %b", out_char, last));
            end
            else
            begin
                want = pending_chars.pop_front();
                if (out_char !== want.ch)
                begin
                    report_mismatch($sformatf("out_char %h, expected %h", out_char, want.ch));
                end
                if (last !== want.last)
                begin
                    report_mismatch($sformatf("last %b, expected %b", last, want.last));
                end
            end
        end
    end

    // Hold start until the word is taken; start stays high for the next word unless idling.
    task automatic send_word(input logic [63:0] v);
        start <= 1'b1;
        value <= v;
        @(posedge clk);
        while (busy)
        begin
            @(posedge clk);
        end
        format_decimal(v);
        if ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 200)) @(posedge clk);
        end
    endtask

    task automatic wait_for_text_done();
        start <= 1'b0;
        while (pending_chars.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // Drain, then let an empty-text word finish before touching registers.
    task automatic settle();
        wait_for_text_done();
        repeat (TAIL_WAIT) @(posedge clk);
        while (busy)
        begin
            @(posedge clk);
        end
    endtask

    task automatic write_reg(input logic [idf_pkg::CFG_IDX_W-1:0] idx,
                             input logic [idf_pkg::CFG_W-1:0] data);
        wr_en    <= 1'b1;
        wr_index <= idx;
        wr_data  <= data;
        @(posedge clk);
        case (idx)
            idf_pkg::REG_FIELD_WIDTH: cfg_width     = data[5:0];
            idf_pkg::REG_MIN_DIGITS:  cfg_precision = data;
            idf_pkg::REG_SHOW_PLUS:   cfg_plus      = data[0];
            idf_pkg::REG_SPACE_SIGN:  cfg_space     = data[0];
            idf_pkg::REG_ZERO_FILL:   cfg_zero_fill = data[0];
            idf_pkg::REG_ALIGN_LEFT:  cfg_left      = data[0];
            idf_pkg::REG_SIGNED_MODE: cfg_signed    = data[0];
            default: ;
        endcase
    endtask

    task automatic set_format(input logic [idf_pkg::CFG_W-1:0] width_d,
                              input logic [idf_pkg::CFG_W-1:0] prec_d,
                              input logic [idf_pkg::CFG_W-1:0] plus_d,
                              input logic [idf_pkg::CFG_W-1:0] space_d,
                              input logic [idf_pkg::CFG_W-1:0] zf_d,
                              input logic [idf_pkg::CFG_W-1:0] left_d,
                              input logic [idf_pkg::CFG_W-1:0] sgn_d);
        settle();
        write_reg(idf_pkg::REG_FIELD_WIDTH, width_d);
        write_reg(idf_pkg::REG_MIN_DIGITS, prec_d);
        write_reg(idf_pkg::REG_SHOW_PLUS, plus_d);
        write_reg(idf_pkg::REG_SPACE_SIGN, space_d);
        write_reg(idf_pkg::REG_ZERO_FILL, zf_d);
        write_reg(idf_pkg::REG_ALIGN_LEFT, left_d);
        write_reg(idf_pkg::REG_SIGNED_MODE, sgn_d);
        wr_en <= 1'b0;
    endtask

    function automatic logic [63:0] random_value();
        logic [63:0] p;
        p = 64'd1;
        case ($urandom_range(0, 5))
            0: return {$urandom, $urandom};
            1: return 64'($urandom_range(0, 999));
            2: return 64'd0 - 64'($urandom_range(0, 999));
            3:
            begin
                repeat ($urandom_range(0, 19)) p = p * 64'd10;
                case ($urandom_range(0, 2))
                    0: return p;
                    1: return p - 64'd1;
                    default: return 64'd0 - p;
                endcase
            end
            4: return {1'b1, 63'd0} + 64'($urandom_range(0, 3)) - 64'd2;
            default: return {$urandom, $urandom} >> $urandom_range(0, 63);
        endcase
    endfunction

    task automatic test_signed_defaults();
        idle_pct = 0;
        set_format(7'd0, 7'h7f, 7'd0, 7'd0, 7'd0, 7'd0, 7'd1);
        send_word(64'd0);
        send_word(64'd1);
        send_word({64{1'b1}});
        send_word({1'b0, {63{1'b1}}});
        send_word({1'b1, 63'd0});
    endtask

    task automatic test_empty_text();
        set_format(7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd1);
        send_word(64'd0);
        send_word(64'd7);
        set_format(7'd0, 7'd0, 7'd1, 7'd0, 7'd0, 7'd0, 7'd1);
        send_word(64'd0);
    endtask

    task automatic test_sign_flags();
        set_format(7'd0, 7'h7f, 7'd1, 7'd1, 7'd0, 7'd0, 7'd1);
        send_word(64'd5);
        set_format(7'd0, 7'h7f, 7'd0, 7'd1, 7'd0, 7'd0, 7'd1);
        send_word(64'd5);
        send_word(64'd0 - 64'd5);
    endtask

    task automatic test_zero_fill();
        set_format(7'd20, 7'h7f, 7'd0, 7'd0, 7'd1, 7'd0, 7'd1);
        send_word(64'd0 - 64'd42);
        set_format(7'd20, 7'd3, 7'd0, 7'd0, 7'd1, 7'd0, 7'd1);
        send_word(64'd0 - 64'd42);
        set_format(7'd20, 7'h7f, 7'd1, 7'd0, 7'd1, 7'd1, 7'd1);
        send_word(64'd42);
    endtask

    task automatic test_unsigned();
        set_format(7'd0, 7'h7f, 7'd1, 7'd1, 7'd0, 7'd0, 7'd0);
        send_word({64{1'b1}});
        send_word({1'b1, 63'd0});
    endtask

    task automatic test_widest_text();
        set_format(7'd63, 7'd62, 7'd0, 7'd0, 7'd0, 7'd0, 7'd1);
        write_reg(REG_NONE, 7'h55);
        wr_en <= 1'b0;
        send_word({1'b1, 63'd0});
        set_format(7'h7f, 7'h7f, 7'd0, 7'd0, 7'd0, 7'd1, 7'd1);
        send_word(64'd1);
        set_format(7'd63, 7'h40, 7'd1, 7'd0, 7'd1, 7'd0, 7'd1);
        send_word(64'd123);
    endtask

    task automatic test_random_formats();
        int                        phase;
        int                        k;
        int                        sel;
        logic [idf_pkg::CFG_W-1:0] width_d;
        logic [idf_pkg::CFG_W-1:0] prec_d;
        for (phase = 0; phase < 8; phase++)
        begin
            case (phase % 4)
                0: idle_pct = 0;
                1: idle_pct = 72;
                2: idle_pct = 0;
                default: idle_pct = 19;
            endcase
            width_d = $urandom_range(0, 9) < 7 ? idf_pkg::CFG_W'($urandom_range(0, 24))
                                               : idf_pkg::CFG_W'($urandom_range(0, 127));
            sel = $urandom_range(0, 9);
            if (sel < 4)
                prec_d = 7'h7f;
            else if (sel < 8)
                prec_d = idf_pkg::CFG_W'($urandom_range(0, 30));
            else if (sel < 9)
                prec_d = idf_pkg::CFG_W'($urandom_range(31, 62));
            else
                prec_d = idf_pkg::CFG_W'($urandom_range(64, 127));
            set_format(width_d, prec_d,
                       {6'($urandom), 1'($urandom)}, {6'($urandom), 1'($urandom)},
                       {6'($urandom), 1'($urandom)}, {6'($urandom), 1'($urandom)},
                       {6'($urandom), 1'($urandom_range(0, 3) != 0)});
            for (k = 0; k < 13; k++)
            begin
                if (k == 7 && phase % 2 == 1)
                begin
                    wait_for_text_done();
                end
                send_word(random_value());
            end
        end
    endtask

    initial
    begin
        #10_000_000;
        $display("integer_decimal_formatter_top verification failed");
        $finish;
    end

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_signed_defaults();
        test_empty_text();
        test_sign_flags();
        test_zero_fill();
        test_unsigned();
        test_widest_text();
        test_random_formats();
        wait_for_text_done();
        repeat (TAIL_WAIT) @(posedge clk);
        if (mismatch_count == 0)
        begin
            $display("integer_decimal_formatter_top verification clean");
        end
        else
        begin
            $display("integer_decimal_formatter_top verification failed");
        end
        $finish;
    end

endmodule
